// ===== hw/rtl/tsbp_pkg.sv =====
package tsbp_pkg;

  localparam int TILE_SHIFT_DEF = 6;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    K_QUANT = 3'd0,
    K_TILE  = 3'd1,
    K_Y     = 3'd2,
    K_CB    = 3'd3,
    K_CR    = 3'd4,
    K_END   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNEXP     = 3'd1,
    ST_SHORT     = 3'd2,
    ST_SUBTYPE   = 3'd3,
    ST_NO_QUANT  = 3'd4,
    ST_TILE_TYPE = 3'd5,
    ST_TILE_LEN  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HEAD      = 3'd1,
    PH_QUANT     = 3'd2,
    PH_TILE_HEAD = 3'd3,
    PH_TILE_BODY = 3'd4
  } phase_t;

  localparam logic [15:0] SUBTYPE_TILESET = 16'hCAC2;
  localparam logic [15:0] BTYPE_TILE      = 16'hCAC3;
  localparam int HEAD_BYTES = 14;
  localparam int TILE_HEAD_BYTES = 6;
  localparam int TILE_HDR_BYTES = 13;

  typedef struct packed {
    logic [2:0]  kind;
    logic [39:0] quant_values;
    logic [7:0]  quant_index_luma;
    logic [7:0]  quant_index_blue;
    logic [7:0]  quant_index_red;
    logic [21:0] pixel_x;
    logic [21:0] pixel_y;
    logic [15:0] luma_length;
    logic [15:0] blue_length;
    logic [15:0] red_length;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
  } result_t;

  // one classified byte: up to two results (main then end status)
  typedef struct packed {
    logic    main_vld;
    result_t main;
    logic    end_vld;
    logic [2:0] end_status;
  } entry_t;

endpackage

// ===== hw/rtl/tsbp_if.sv =====
interface tsbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  logic       last;
  logic       tileset_expected;
  modport source(output valid, data_byte, first, last, tileset_expected, input ready);
  modport sink(input valid, data_byte, first, last, tileset_expected, output ready);
endinterface

interface tsbp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [39:0] quant_values;
  logic [7:0]  quant_index_luma;
  logic [7:0]  quant_index_blue;
  logic [7:0]  quant_index_red;
  logic [21:0] pixel_x;
  logic [21:0] pixel_y;
  logic [15:0] luma_length;
  logic [15:0] blue_length;
  logic [15:0] red_length;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  modport source(output valid, kind, quant_values, quant_index_luma, quant_index_blue,
                 quant_index_red, pixel_x, pixel_y, luma_length, blue_length, red_length,
                 payload_byte, status, input ready);
  modport sink(input valid, kind, quant_values, quant_index_luma, quant_index_blue,
               quant_index_red, pixel_x, pixel_y, luma_length, blue_length, red_length,
               payload_byte, status, output ready);
endinterface

// ===== hw/rtl/tileset_block_parser.sv =====
// Results of an accepted byte are queued and presented in order from the queue head.
// Throughput: one byte per cycle while the queue has room; a byte yielding
// two results (data then end status) queues both in one entry, shown in turn.
// Input stalls only when the output queue is full.
// Reset: synchronous, active high; parser idles and queue empties.
module tileset_block_parser #(
  parameter int TILE_SHIFT = tsbp_pkg::TILE_SHIFT_DEF
) (
  input logic        clk,
  input logic        rst,
  tsbp_in_if.sink    in,
  tsbp_out_if.source out
);

  tsbp_pkg::entry_t entry;
  logic room, take, push;

  // front classifies each byte; bytes producing no result never enter the queue
  assign in.ready = room;
  assign take = in.valid && in.ready;
  assign push = take && (entry.main_vld || entry.end_vld);

  tsbp_front #(.TILE_SHIFT(TILE_SHIFT)) u_front (
    .clk, .rst, .take,
    .data_byte(in.data_byte), .first(in.first), .last(in.last),
    .tileset_expected(in.tileset_expected), .entry
  );

  tsbp_back u_back (
    .clk, .rst, .push, .push_entry(entry), .has_room(room), .out
  );

endmodule

// ===== hw/rtl/tsbp_front.sv =====
module tsbp_front #(
  parameter int TILE_SHIFT = tsbp_pkg::TILE_SHIFT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       data_byte,
  input  logic             first,
  input  logic             last,
  input  logic             tileset_expected,
  output tsbp_pkg::entry_t entry
);

  tsbp_pkg::phase_t phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [7:0]  quant_count, quant_count_next;
  logic [15:0] tiles_total, tiles_total_next;
  logic [15:0] tiles_done, tiles_done_next;
  logic [31:0] block_length, block_length_next;
  logic [31:0] field_shift, field_shift_next;
  logic [47:0] span_lengths, span_lengths_next;
  logic [7:0]  hdr [13];
  logic [2:0]  tile_err, tile_err_next;
  logic [2:0]  qpos, qpos_next;
  logic [16:0] sum_yc, sum_yc_next;
  logic [17:0] sum_all, sum_all_next;
  logic        hdr_we;
  logic [3:0]  hdr_wa;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tsbp_pkg::PH_IDLE;
      byte_count <= '0;
      quant_count <= '0;
      tiles_total <= '0;
      tiles_done <= '0;
      block_length <= '0;
      field_shift <= '0;
      span_lengths <= '0;
      tile_err <= '0;
      qpos <= '0;
      sum_yc <= '0;
      sum_all <= '0;
    end else if (take) begin
      phase <= phase_next;
      byte_count <= byte_count_next;
      quant_count <= quant_count_next;
      tiles_total <= tiles_total_next;
      tiles_done <= tiles_done_next;
      block_length <= block_length_next;
      field_shift <= field_shift_next;
      span_lengths <= span_lengths_next;
      tile_err <= tile_err_next;
      qpos <= qpos_next;
      sum_yc <= sum_yc_next;
      sum_all <= sum_all_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && hdr_we) hdr[hdr_wa] <= data_byte;
  end

  always_comb begin
    logic [15:0] yl, cbl, crl, xi, yi, subtype, btype;
    logic [31:0] blen, cnt1, off;
    logic [21:0] px, py;
    phase_next = phase;
    byte_count_next = byte_count;
    quant_count_next = quant_count;
    tiles_total_next = tiles_total;
    tiles_done_next = tiles_done;
    block_length_next = block_length;
    field_shift_next = field_shift;
    span_lengths_next = span_lengths;
    tile_err_next = tile_err;
    qpos_next = qpos;
    sum_yc_next = sum_yc;
    sum_all_next = sum_all;
    hdr_we = 1'b0;
    hdr_wa = byte_count[3:0];
    entry = '0;
    yl = '0; cbl = '0; crl = '0; xi = '0; yi = '0; subtype = '0; btype = '0;
    blen = '0; off = '0; px = '0; py = '0;
    cnt1 = byte_count + 32'd1;
    if (first) begin
      byte_count_next = '0;
      cnt1 = 32'd1;
      quant_count_next = '0;
      tiles_total_next = '0;
      tiles_done_next = '0;
      block_length_next = '0;
      field_shift_next = '0;
      span_lengths_next = '0;
      tile_err_next = '0;
      qpos_next = '0;
      hdr_wa = '0;
    end
    if (first && !tileset_expected) begin
      entry.end_vld = 1'b1;
      entry.end_status = tsbp_pkg::ST_UNEXP;
      phase_next = tsbp_pkg::PH_IDLE;
    end else begin
      unique case (first ? tsbp_pkg::PH_HEAD : phase)
        tsbp_pkg::PH_HEAD: begin
          hdr_we = (cnt1 <= 32'd13);
          byte_count_next = cnt1;
          phase_next = tsbp_pkg::PH_HEAD;
          if (cnt1 == 32'(tsbp_pkg::HEAD_BYTES)) begin
            subtype = {hdr[1], hdr[0]};
            quant_count_next = hdr[6];
            tiles_total_next = {hdr[9], hdr[8]};
            if (subtype != tsbp_pkg::SUBTYPE_TILESET) begin
              entry.end_vld = 1'b1; entry.end_status = tsbp_pkg::ST_SUBTYPE;
              phase_next = tsbp_pkg::PH_IDLE;
            end else if (hdr[6] == 8'd0) begin
              entry.end_vld = 1'b1; entry.end_status = tsbp_pkg::ST_NO_QUANT;
              phase_next = tsbp_pkg::PH_IDLE;
            end else if ({hdr[9], hdr[8]} == 16'd0) begin
              entry.end_vld = 1'b1; entry.end_status = tsbp_pkg::ST_OK;
              phase_next = tsbp_pkg::PH_IDLE;
            end else begin
              phase_next = tsbp_pkg::PH_QUANT;
              byte_count_next = '0;
              field_shift_next = '0;
              qpos_next = '0;
            end
          end
        end
        tsbp_pkg::PH_QUANT: begin
          byte_count_next = cnt1;
          unique case (qpos)
            3'd0: field_shift_next[7:0] = data_byte;
            3'd1: field_shift_next[15:8] = data_byte;
            3'd2: field_shift_next[23:16] = data_byte;
            3'd3: field_shift_next[31:24] = data_byte;
            default: ;
          endcase
          if (qpos == 3'd4) begin
            entry.main_vld = 1'b1;
            entry.main.kind = tsbp_pkg::K_QUANT;
            entry.main.quant_values = {data_byte, field_shift};
            field_shift_next = '0;
            qpos_next = '0;
          end else begin
            qpos_next = qpos + 3'd1;
          end
          // five bytes per quant set
          if (cnt1 >= {24'd0, quant_count} * 32'd5) begin
            phase_next = tsbp_pkg::PH_TILE_HEAD;
            byte_count_next = '0;
          end
        end
        tsbp_pkg::PH_TILE_HEAD: begin
          hdr_we = 1'b1;
          byte_count_next = cnt1;
          if (cnt1 == 32'(tsbp_pkg::TILE_HEAD_BYTES)) begin
            btype = {hdr[1], hdr[0]};
            blen = {data_byte, hdr[4], hdr[3], hdr[2]};
            block_length_next = blen;
            if (blen < 32'd19) tile_err_next = tsbp_pkg::ST_TILE_LEN;
            else if (btype != tsbp_pkg::BTYPE_TILE) tile_err_next = tsbp_pkg::ST_TILE_TYPE;
            else tile_err_next = tsbp_pkg::ST_OK;
            if (blen <= 32'd6) begin
              entry.end_vld = 1'b1; entry.end_status = tsbp_pkg::ST_TILE_LEN;
              phase_next = tsbp_pkg::PH_IDLE;
            end else begin
              phase_next = tsbp_pkg::PH_TILE_BODY;
              byte_count_next = '0;
            end
          end
        end
        tsbp_pkg::PH_TILE_BODY: begin
          byte_count_next = cnt1;
          if (tile_err == tsbp_pkg::ST_OK) begin
            if (byte_count < 32'd13) begin
              hdr_we = 1'b1;
              if (byte_count == 32'd12) begin
                yl = {hdr[8], hdr[7]};
                cbl = {hdr[10], hdr[9]};
                crl = {data_byte, hdr[11]};
                span_lengths_next = {crl, cbl, yl};
                sum_yc_next = {1'b0, yl} + {1'b0, cbl};
                sum_all_next = {2'b0, yl} + {2'b0, cbl} + {2'b0, crl};
                if ({14'd0, sum_all_next} > block_length - 32'd19) begin
                  tile_err_next = tsbp_pkg::ST_TILE_LEN;
                end else begin
                  xi = {hdr[4], hdr[3]};
                  yi = {hdr[6], hdr[5]};
                  px = 22'({6'd0, xi} << TILE_SHIFT);
                  py = 22'({6'd0, yi} << TILE_SHIFT);
                  entry.main_vld = 1'b1;
                  entry.main.kind = tsbp_pkg::K_TILE;
                  entry.main.quant_index_luma = hdr[0];
                  entry.main.quant_index_blue = hdr[1];
                  entry.main.quant_index_red = hdr[2];
                  entry.main.pixel_x = px;
                  entry.main.pixel_y = py;
                  entry.main.luma_length = yl;
                  entry.main.blue_length = cbl;
                  entry.main.red_length = crl;
                end
              end
            end else begin
              off = byte_count - 32'd13;
              entry.main.payload_byte = data_byte;
              if (off < {16'd0, span_lengths[15:0]}) begin
                entry.main_vld = 1'b1; entry.main.kind = tsbp_pkg::K_Y;
              end else if (off < {15'd0, sum_yc}) begin
                entry.main_vld = 1'b1; entry.main.kind = tsbp_pkg::K_CB;
              end else if (off < {14'd0, sum_all}) begin
                entry.main_vld = 1'b1; entry.main.kind = tsbp_pkg::K_CR;
              end else begin
                entry.main.payload_byte = '0;
              end
            end
          end
          if (cnt1 >= block_length - 32'd6) begin
            if (tile_err_next != tsbp_pkg::ST_OK) begin
              entry.end_vld = 1'b1; entry.end_status = tile_err_next;
              phase_next = tsbp_pkg::PH_IDLE;
            end else begin
              tiles_done_next = tiles_done + 16'd1;
              if (tiles_done_next >= tiles_total) begin
                entry.end_vld = 1'b1; entry.end_status = tsbp_pkg::ST_OK;
                phase_next = tsbp_pkg::PH_IDLE;
              end else begin
                phase_next = tsbp_pkg::PH_TILE_HEAD;
                byte_count_next = '0;
              end
            end
          end
        end
        default: ;
      endcase
      if (last && phase_next != tsbp_pkg::PH_IDLE) begin
        entry.end_vld = 1'b1;
        entry.end_status = tsbp_pkg::ST_SHORT;
        phase_next = tsbp_pkg::PH_IDLE;
      end
    end
  end

endmodule

// ===== hw/rtl/tsbp_back.sv =====
module tsbp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tsbp_pkg::entry_t push_entry,
  output logic             has_room,
  tsbp_out_if.source       out
);

  localparam int D = tsbp_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(D);

  tsbp_pkg::entry_t mem [D];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic          main_done;
  tsbp_pkg::entry_t head;
  logic          pop, is_main;

  assign head = mem[rp];
  assign has_room = (cnt < (AW+1)'(D));
  assign is_main = head.main_vld && !main_done;
  assign out.valid = (cnt != '0);
  assign pop = out.valid && out.ready && (!is_main || !head.end_vld);

  always_comb begin
    tsbp_pkg::result_t r;
    r = '0;
    if (is_main) r = head.main;
    else begin
      r.kind = tsbp_pkg::K_END;
      r.status = head.end_status;
    end
    out.kind = r.kind;
    out.quant_values = r.quant_values;
    out.quant_index_luma = r.quant_index_luma;
    out.quant_index_blue = r.quant_index_blue;
    out.quant_index_red = r.quant_index_red;
    out.pixel_x = r.pixel_x;
    out.pixel_y = r.pixel_y;
    out.luma_length = r.luma_length;
    out.blue_length = r.blue_length;
    out.red_length = r.red_length;
    out.payload_byte = r.payload_byte;
    out.status = r.status;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; main_done <= 1'b0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) begin
        rp <= rp + 1'b1;
        main_done <= 1'b0;
      end else if (out.valid && out.ready) begin
        main_done <= 1'b1;
      end
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= (AW+1)'(D));
  assert property (@(posedge clk) disable iff (rst) push |-> (push_entry.main_vld || push_entry.end_vld))
    else $error("empty entry queued");
  assert property (@(posedge clk) disable iff (rst) main_done |-> head.end_vld)
    else $error("split without end");

endmodule
